>>> src/mm_pkg.sv
// Shared constants, types and helpers for the matrix multiply unit.
`default_nettype none

package mm_pkg;

    // Matrix size limits
    localparam int MAX_ROWS  = 64;
    localparam int MAX_INNER = 64;
    localparam int MAX_COLS  = 64;

    localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH = MAX_INNER * MAX_COLS;
    localparam int A_AW    = $clog2(A_DEPTH);
    localparam int B_AW    = $clog2(B_DEPTH);

    // Field widths
    localparam int SIZE_W  = 7;
    localparam int IDX_W   = 12;
    localparam int ELEM_W  = 16;
    localparam int POS_W   = 6;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = PROD_W + $clog2(MAX_INNER) + 1;
    localparam int CFG_IW  = 2;
    localparam int LIM_W   = 2 * SIZE_W;

    // Request codes
    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_COLS_B    = 2'd2;

    // Saturation bounds for the accumulator
    localparam logic signed [ACC_W-1:0] ACC_SAT_HI =
        {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_SAT_LO =
        {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // write the accepted load beat into A or B
        logic start;     // latch a compute request, clear the sum
        logic issue;     // read one A/B pair and step the addresses
        logic mul_en;    // multiply the pair read last cycle
        logic acc_en;    // add the registered product into the sum
        logic out_load;  // move the finished result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;       // the pair being issued is the last one
        logic range_err;  // the offered compute names a row or column out of range
    } t_dp_stat;

    // Clamp a written size into 1..max
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int max_v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (r == '0) begin
            r = SIZE_W'(1);
        end
        if (int'(r) > max_v) begin
            r = SIZE_W'(max_v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/mm_datapath.sv
// Datapath: size registers, A and B stores, address stepping, multiply-accumulate, result.
`default_nettype none

module mm_datapath
    import mm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IW-1:0]        i_cfg_index,
    input  wire logic [SIZE_W-1:0]        i_cfg_data,
    input  wire logic [1:0]               i_req_type,
    input  wire logic [IDX_W-1:0]         i_elem_index,
    input  wire logic signed [ELEM_W-1:0] i_elem_value,
    input  wire logic [POS_W-1:0]         i_out_row,
    input  wire logic [POS_W-1:0]         i_out_col,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    output logic signed [VAL_W-1:0]       o_product_value,
    output logic [POS_W-1:0]              o_res_row,
    output logic [POS_W-1:0]              o_res_col,
    output logic                          o_status
);

    logic [SIZE_W-1:0] r_rows, r_inner, r_cols;

    logic signed [ELEM_W-1:0] mem_a [A_DEPTH];
    logic signed [ELEM_W-1:0] mem_b [B_DEPTH];

    logic [A_AW-1:0]          r_a_addr;
    logic [B_AW-1:0]          r_b_addr;
    logic [SIZE_W-1:0]        r_k;
    logic signed [ELEM_W-1:0] r_a_rd, r_b_rd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [POS_W-1:0]         r_row, r_col;
    logic                     r_err;

    logic [LIM_W-1:0]         a_lim, b_lim, a_base;
    logic                     a_we, b_we;
    logic signed [VAL_W-1:0]  sat_value;

    // Size registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= SIZE_W'(1);
            r_inner <= SIZE_W'(1);
            r_cols  <= SIZE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS_A:    r_rows  <= clamp_size(i_cfg_data, MAX_ROWS);
                CFG_INNER_DIM: r_inner <= clamp_size(i_cfg_data, MAX_INNER);
                CFG_COLS_B:    r_cols  <= clamp_size(i_cfg_data, MAX_COLS);
                default: begin
                end
            endcase
        end
    end

    // Load range checks; drop loads past the configured shape
    assign a_lim = LIM_W'(r_rows) * LIM_W'(r_inner);
    assign b_lim = LIM_W'(r_inner) * LIM_W'(r_cols);
    assign a_we  = i_cmd.load && (i_req_type == REQ_LOAD_A)
                   && (LIM_W'(i_elem_index) < a_lim) && (int'(i_elem_index) < A_DEPTH);
    assign b_we  = i_cmd.load && (i_req_type == REQ_LOAD_B)
                   && (LIM_W'(i_elem_index) < b_lim) && (int'(i_elem_index) < B_DEPTH);

    // Element stores
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            mem_a[i_elem_index[A_AW-1:0]] <= i_elem_value;
        end
        if (i_cmd.issue) begin
            r_a_rd <= mem_a[r_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            mem_b[i_elem_index[B_AW-1:0]] <= i_elem_value;
        end
        if (i_cmd.issue) begin
            r_b_rd <= mem_b[r_b_addr];
        end
    end

    // Range check of the offered compute request
    assign o_stat.range_err = ({1'b0, i_out_row} >= r_rows) || ({1'b0, i_out_col} >= r_cols);
    assign o_stat.last      = (r_k == r_inner - SIZE_W'(1));

    // Latch the request and walk row of A along k, column of B down k
    assign a_base = LIM_W'(i_out_row) * LIM_W'(r_inner);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a_addr <= a_base[A_AW-1:0];
            r_b_addr <= B_AW'(i_out_col);
            r_k      <= '0;
            r_row    <= i_out_row;
            r_col    <= i_out_col;
            r_err    <= o_stat.range_err;
        end else if (i_cmd.issue) begin
            r_a_addr <= r_a_addr + A_AW'(1);
            r_b_addr <= r_b_addr + B_AW'(r_cols);
            r_k      <= r_k + SIZE_W'(1);
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= r_a_rd * r_b_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // Saturate to the result width
    always_comb begin
        if (r_acc > ACC_SAT_HI) begin
            sat_value = ACC_SAT_HI[VAL_W-1:0];
        end else if (r_acc < ACC_SAT_LO) begin
            sat_value = ACC_SAT_LO[VAL_W-1:0];
        end else begin
            sat_value = r_acc[VAL_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_product_value <= sat_value;
            o_res_row       <= r_row;
            o_res_col       <= r_col;
            o_status        <= r_err;
        end
    end

endmodule

`default_nettype wire

>>> src/mm_ctrl.sv
// Controller: request decode, dot-product sequencing and output handshake.
`default_nettype none

module mm_ctrl
    import mm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_req_type,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_v1, r_v2;
    logic   accept, out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_en = r_v1;
        o_cmd.acc_en = r_v2;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_LOAD_A, REQ_LOAD_B: begin
                            o_cmd.load = 1'b1;
                        end
                        REQ_COMPUTE: begin
                            o_cmd.start = 1'b1;
                            n_state = i_stat.range_err ? ST_FINISH : ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, pipeline valid flags, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= o_cmd.issue;
            r_v2    <= r_v1;
            if (o_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/matrix_multiply_unit.sv
// Top level of the matrix multiply unit: controller plus datapath.
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     req_type, elem_index, elem_value,
//                                                   out_row, out_col
//  output    out        o_out_valid / i_out_ready   product_value, res_row, res_col, status
//  config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// A compute beat in range reads one A/B pair per cycle from the A and B stores,
// then the read, multiply and accumulate register stages drain before the result.
// A compute beat out of range returns status 1 with value 0.
// Reset restores all sizes to 1 and empties the output register; the stores are not cleared.
// A result held by a low i_out_ready stalls only the next compute; loads still go in.
`default_nettype none

module matrix_multiply_unit
    import mm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IW-1:0]        i_cfg_index,
    input  wire logic [SIZE_W-1:0]        i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_req_type,
    input  wire logic [IDX_W-1:0]         i_elem_index,
    input  wire logic signed [ELEM_W-1:0] i_elem_value,
    input  wire logic [POS_W-1:0]         i_out_row,
    input  wire logic [POS_W-1:0]         i_out_col,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [VAL_W-1:0]       o_product_value,
    output logic [POS_W-1:0]              o_res_row,
    output logic [POS_W-1:0]              o_res_col,
    output logic                          o_status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_elem_index    (i_elem_index),
        .i_elem_value    (i_elem_value),
        .i_out_row       (i_out_row),
        .i_out_col       (i_out_col),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_product_value (o_product_value),
        .o_res_row       (o_res_row),
        .o_res_col       (o_res_col),
        .o_status        (o_status)
    );

`ifndef ASSERT_OFF
    // A compute beat closes the input until its result is moved into the output register
    a_compute_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_req_type == REQ_COMPUTE) |=> !o_in_ready)
        else $error("input ready while a compute is in flight");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten");

    // An out-of-range result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> (o_product_value == '0))
        else $error("error result with nonzero value");

    // Store reads happen only while the input is closed
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> !o_in_ready)
        else $error("store read while accepting input");
`endif

endmodule

`default_nettype wire

>>> tb/matrix_multiply_unit_tb.sv
// Self-checking testbench for the matrix multiply unit: loads, dot-product requests, sizing.
module matrix_multiply_unit_tb
    import mm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 7;
    localparam int DRAIN_CYCLES     = 80;    // outlasts the longest compute
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 12;
    localparam int MAX_REPORTS      = 40;

    // Codes the package leaves unnamed
    localparam logic [1:0]        REQ_UNUSED   = 2'd3;
    localparam logic [CFG_IW-1:0] CFG_UNUSED   = 2'd3;
    localparam logic              STATUS_OK    = 1'b0;
    localparam logic              STATUS_RANGE = 1'b1;

    localparam logic [ELEM_W-1:0] ELEM_MIN = 16'h8000;
    localparam logic [ELEM_W-1:0] ELEM_MAX = 16'h7FFF;
    localparam longint            SUM_MAX  = 64'sd2147483647;
    localparam longint            SUM_MIN  = -64'sd2147483648;

    // Sizing phases with fixed shapes: raw register values, some outside 1..64
    localparam int N_SHAPED = 5;
    localparam int N_PHASES = 11;
    localparam int SHAPE_ROWS  [N_SHAPED] = '{4, 0, 64, 2, 100};
    localparam int SHAPE_INNER [N_SHAPED] = '{4, 127, 1, 64, 2};
    localparam int SHAPE_COLS  [N_SHAPED] = '{4, 0, 64, 2, 0};
    localparam bit SHAPE_EXTREME [N_SHAPED] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    // Idling modes: none, sender idle, receiver stalled, both
    localparam int IN_IDLE_PCT   [4] = '{0, 64, 0, 35};
    localparam int OUT_STALL_PCT [4] = '{0, 0, 64, 35};

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  index;
        logic [ELEM_W-1:0] value;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } t_mm_request;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             status;
    } t_mm_result;

    // Mirror of the stores and sizes; queue of products still owed by the block
    class mm_result_board;
        logic [ELEM_W-1:0] a_store [A_DEPTH];
        logic [ELEM_W-1:0] b_store [B_DEPTH];
        int unsigned rows_used;
        int unsigned inner_used;
        int unsigned cols_used;
        t_mm_result pending_products [$];
        int unsigned n_requests;
        int unsigned n_loads;
        int unsigned n_computes;
        int unsigned n_checked;
        int unsigned n_range_err;
        int unsigned n_saturated;
        int unsigned n_errors;

        function new();
            foreach (a_store[i]) a_store[i] = '0;
            foreach (b_store[i]) b_store[i] = '0;
            rows_used   = 1;
            inner_used  = 1;
            cols_used   = 1;
            n_requests  = 0;
            n_loads     = 0;
            n_computes  = 0;
            n_checked   = 0;
            n_range_err = 0;
            n_saturated = 0;
            n_errors    = 0;
        endfunction

        function int unsigned clamp_dim(logic [SIZE_W-1:0] raw, int unsigned top);
            if (raw == '0) return 1;
            if (int'(raw) > top) return top;
            return int'(raw);
        endfunction

        function void set_size(logic [CFG_IW-1:0] idx, logic [SIZE_W-1:0] data);
            case (idx)
                CFG_ROWS_A:    rows_used  = clamp_dim(data, MAX_ROWS);
                CFG_INNER_DIM: inner_used = clamp_dim(data, MAX_INNER);
                CFG_COLS_B:    cols_used  = clamp_dim(data, MAX_COLS);
                default: ;
            endcase
        endfunction

        // Sum the row of A against the column of B exactly, then saturate to signed 32-bit integer (Q32.0)
        function logic [VAL_W-1:0] dot_product_of(int unsigned row, int unsigned col);
            longint sum;
            int unsigned k;
            sum = 0;
            for (k = 0; k < inner_used; k++) begin
                sum += longint'($signed(a_store[row * inner_used + k])) *
                       longint'($signed(b_store[k * cols_used + col]));
            end
            if (sum > SUM_MAX) begin
                sum = SUM_MAX;
                n_saturated++;
            end else if (sum < SUM_MIN) begin
                sum = SUM_MIN;
                n_saturated++;
            end
            return VAL_W'(sum);
        endfunction

        function void note_request(t_mm_request r);
            t_mm_result owed;
            n_requests++;
            case (r.kind)
                REQ_LOAD_A: begin
                    n_loads++;
                    if (int'(r.index) < rows_used * inner_used) a_store[r.index] = r.value;
                end
                REQ_LOAD_B: begin
                    n_loads++;
                    if (int'(r.index) < inner_used * cols_used) b_store[r.index] = r.value;
                end
                REQ_COMPUTE: begin
                    n_computes++;
                    owed.row = r.row;
                    owed.col = r.col;
                    if (int'(r.row) >= rows_used || int'(r.col) >= cols_used) begin
                        owed.value  = '0;
                        owed.status = STATUS_RANGE;
                        n_range_err++;
                    end else begin
                        owed.value  = dot_product_of(int'(r.row), int'(r.col));
                        owed.status = STATUS_OK;
                    end
                    pending_products.insert(pending_products.size(), owed);
                end
                default: ;
            endcase
        endfunction

        function void flag_field(string field, logic signed [VAL_W-1:0] want_v,
                                 logic signed [VAL_W-1:0] got_v);
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want_v, got_v);
        endfunction

        function void check_result(t_mm_result got);
            t_mm_result want;
            if (pending_products.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display({"%0t: unexpected result: expected none, ",
                              "actual value %0d row %0d col %0d status %0d"},
                             $time, $signed(got.value), got.row, got.col, got.status);
                return;
            end
            want = pending_products.pop_front();
            n_checked++;
            if (got.value !== want.value)
                flag_field("product_value", want.value, got.value);
            if (got.row !== want.row)
                flag_field("res_row", VAL_W'(want.row), VAL_W'(got.row));
            if (got.col !== want.col)
                flag_field("res_col", VAL_W'(want.col), VAL_W'(got.col));
            if (got.status !== want.status)
                flag_field("status", VAL_W'(want.status), VAL_W'(got.status));
        endfunction

        // Count products that never showed up
        function void close_out();
            if (pending_products.size() != 0) begin
                $display("%0t: %0d results never arrived, first owed row %0d col %0d",
                         $time, pending_products.size(), pending_products[0].row,
                         pending_products[0].col);
                n_errors += pending_products.size();
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IW-1:0]        i_cfg_index;
    logic [SIZE_W-1:0]        i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [1:0]               i_req_type;
    logic [IDX_W-1:0]         i_elem_index;
    logic signed [ELEM_W-1:0] i_elem_value;
    logic [POS_W-1:0]         i_out_row;
    logic [POS_W-1:0]         i_out_col;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [VAL_W-1:0]  o_product_value;
    logic [POS_W-1:0]         o_res_row;
    logic [POS_W-1:0]         o_res_col;
    logic                     o_status;

    mm_result_board board;
    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned n_settings    = 0;

    matrix_multiply_unit u_top (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Record every accepted request beat
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready === 1'b1)
            board.note_request('{i_req_type, i_elem_index, i_elem_value, i_out_row, i_out_col});
    end

    // Check each accepted result beat, then pick the next ready level
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_ready)
            board.check_result('{o_product_value, o_res_row, o_res_col, o_status});
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic t_mm_request make_request(logic [1:0] kind, int index, int value,
                                                 int row, int col);
        t_mm_request r;
        r.kind  = kind;
        r.index = IDX_W'(index);
        r.value = ELEM_W'(value);
        r.row   = POS_W'(row);
        r.col   = POS_W'(col);
        return r;
    endfunction

    // Favor the two extremes when asked, else mostly uniform
    function automatic logic [ELEM_W-1:0] pick_element(bit extremes);
        int unsigned roll;
        roll = $urandom_range(99);
        if (extremes) begin
            if (roll < 40) return ELEM_MIN;
            if (roll < 80) return ELEM_MAX;
        end else if (roll < 8) begin
            return (roll < 4) ? ELEM_MIN : ELEM_MAX;
        end
        return ELEM_W'($urandom);
    endfunction

    // Mostly in-range loads and computes; some stray requests and unused codes
    function automatic t_mm_request random_request(bit extremes);
        int unsigned roll;
        int unsigned a_span;
        int unsigned b_span;
        roll   = $urandom_range(99);
        a_span = board.rows_used * board.inner_used;
        b_span = board.inner_used * board.cols_used;
        if (roll < 30)
            return make_request(REQ_COMPUTE, $urandom, $urandom,
                                $urandom_range(board.rows_used - 1),
                                $urandom_range(board.cols_used - 1));
        if (roll < 40)
            return make_request(REQ_COMPUTE, $urandom, $urandom, $urandom, $urandom);
        if (roll < 70)
            return make_request(REQ_LOAD_A, $urandom_range(a_span - 1), pick_element(extremes),
                                $urandom, $urandom);
        if (roll < 85)
            return make_request(REQ_LOAD_B, $urandom_range(b_span - 1), pick_element(extremes),
                                $urandom, $urandom);
        if (roll < 95)
            return make_request(roll[0] ? REQ_LOAD_B : REQ_LOAD_A, $urandom,
                                pick_element(extremes), $urandom, $urandom);
        return make_request(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Offer one beat, idling first at random; hold it until accepted
    task automatic push_request(input t_mm_request r);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= r.kind;
        i_elem_index <= r.index;
        i_elem_value <= r.value;
        i_out_row    <= r.row;
        i_out_col    <= r.col;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle
    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_products.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [SIZE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.set_size(idx, data);
    endtask

    task automatic apply_sizes(input int rows_raw, input int inner_raw, input int cols_raw);
        write_reg(CFG_ROWS_A, SIZE_W'(rows_raw));
        write_reg(CFG_INNER_DIM, SIZE_W'(inner_raw));
        write_reg(CFG_COLS_B, SIZE_W'(cols_raw));
        write_reg(CFG_UNUSED, SIZE_W'($urandom));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic select_idling(input int mode);
        in_idle_pct   = IN_IDLE_PCT[mode];
        out_stall_pct = OUT_STALL_PCT[mode];
    endtask

    // Fill both matrices at the current sizes, then run a random mix
    task automatic run_phase(input bit extremes);
        int unsigned i;
        for (i = 0; i < board.rows_used * board.inner_used; i++)
            push_request(make_request(REQ_LOAD_A, i, pick_element(extremes), $urandom, $urandom));
        for (i = 0; i < board.inner_used * board.cols_used; i++)
            push_request(make_request(REQ_LOAD_B, i, pick_element(extremes), $urandom, $urandom));
        for (i = 0; i < RANDOM_PER_PHASE; i++)
            push_request(random_request(extremes));
        drain_block();
    endtask

    initial begin
        int p;
        board = new();

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_req_type   <= '0;
        i_elem_index <= '0;
        i_elem_value <= '0;
        i_out_row    <= '0;
        i_out_col    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening at the reset sizes of one by one by one
        select_idling(0);
        push_request(make_request(REQ_COMPUTE, 0, 0, 63, 63));        // both out of range
        push_request(make_request(REQ_COMPUTE, 0, 0, 0, 1));          // column out of range
        push_request(make_request(REQ_COMPUTE, 0, 0, 1, 0));          // row out of range
        push_request(make_request(REQ_UNUSED, 4095, -1, 63, 63));     // unused code
        push_request(make_request(REQ_LOAD_A, 0, ELEM_MIN, 0, 0));
        push_request(make_request(REQ_LOAD_B, 0, ELEM_MIN, 63, 63));
        push_request(make_request(REQ_COMPUTE, 4095, -1, 0, 0));
        push_request(make_request(REQ_LOAD_A, 1, ELEM_MAX, 0, 0));    // out-of-range loads
        push_request(make_request(REQ_LOAD_B, 4095, ELEM_MAX, 0, 0));
        push_request(make_request(REQ_LOAD_A, 4095, 0, 0, 0));
        push_request(make_request(REQ_COMPUTE, 0, 0, 0, 0));
        push_request(make_request(REQ_LOAD_A, 0, ELEM_MAX, 0, 0));
        push_request(make_request(REQ_COMPUTE, 0, 0, 0, 0));
        push_request(make_request(REQ_LOAD_B, 0, ELEM_MAX, 0, 0));
        push_request(make_request(REQ_COMPUTE, 0, 0, 0, 0));
        push_request(make_request(REQ_LOAD_A, 0, -1, 0, 0));
        push_request(make_request(REQ_LOAD_B, 0, 1, 0, 0));
        push_request(make_request(REQ_COMPUTE, 0, 0, 0, 0));
        push_request(make_request(REQ_LOAD_A, 0, 0, 0, 0));
        push_request(make_request(REQ_COMPUTE, 0, 0, 0, 0));
        drain_block();

        // Sizing phases: fixed shapes first, then small random shapes
        for (p = 0; p < N_PHASES; p++) begin
            select_idling((p + 1) % 4);
            if (p < N_SHAPED) begin
                apply_sizes(SHAPE_ROWS[p], SHAPE_INNER[p], SHAPE_COLS[p]);
                run_phase(SHAPE_EXTREME[p]);
            end else begin
                apply_sizes($urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1));
                run_phase($urandom_range(2) == 0);
            end
        end

        board.close_out();
        $display("Sent %0d request beats (%0d loads, %0d computes) over %0d size settings.",
                 board.n_requests, board.n_loads, board.n_computes, n_settings + 1);
        $display("Checked %0d results: %0d range errors, %0d saturated sums, %0d mismatches.",
                 board.n_checked, board.n_range_err, board.n_saturated, board.n_errors);
        if (board.n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/mm_pkg.sv
src/mm_datapath.sv
src/mm_ctrl.sv
src/matrix_multiply_unit.sv
tb/matrix_multiply_unit_tb.sv
